FILE: sv/chlb64_pkg.sv
// Package: types, codes and the base64 lookup shared by the link id extractor.
`timescale 1ns / 1ps
package chlb64_pkg;

  localparam int CHAR_W   = 8;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;
  localparam int ACC_W    = 12;
  localparam int PEND_W   = 4;
  localparam int COUNT_W  = 3;

  localparam logic [CHAR_W-1:0] CHAR_OPEN_BRACKET  = 8'h5B;
  localparam logic [CHAR_W-1:0] CHAR_AMPERSAND     = 8'h26;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE_BRACKET = 8'h5D;
  localparam logic [CHAR_W-1:0] CHAR_PAD           = 8'h3D;

  localparam logic signed [PEND_W-1:0] PEND_RESET = -4'sd8;
  localparam logic [COUNT_W-1:0]       COUNT_FULL = 3'd5;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_DECODE = 2'd1,
    PH_PADDED = 2'd2,
    PH_CLOSED = 2'd3
  } scan_phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_LINK    = 2'd1,
    ST_UNTERM     = 2'd2,
    ST_SHORT      = 2'd3
  } parse_status_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } b64_code_t;

  typedef struct packed {
    logic [ID_W-1:0]     link_id;
    logic [STATUS_W-1:0] parse_status;
  } result_word_t;

  function automatic b64_code_t b64_lookup(input logic [CHAR_W-1:0] c);
    b64_code_t r;
    r.hit   = 1'b1;
    r.value = 6'd0;
    case (c) inside
      [8'h41:8'h5A]: r.value = 6'(c - 8'h41);
      [8'h61:8'h7A]: r.value = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.value = 6'(c - 8'h30 + 8'd52);
      8'h2B:         r.value = 6'd62;
      8'h2F:         r.value = 6'd63;
      default:       r.hit   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/chlb64_ifs.sv
// Interfaces: character input channel and result output channel.
`timescale 1ns / 1ps
interface chlb64_char_if;
  logic                          valid;
  logic                          ready;
  logic [chlb64_pkg::CHAR_W-1:0] text_char;
  logic                          end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface chlb64_result_if;
  logic                            valid;
  logic                            ready;
  logic [chlb64_pkg::ID_W-1:0]     link_id;
  logic [chlb64_pkg::STATUS_W-1:0] parse_status;

  modport source (output valid, output link_id, output parse_status, input ready);
  modport sink   (input valid, input link_id, input parse_status, output ready);
endinterface

FILE: sv/chat_link_base64_id_extractor.sv
// Top level: chat link finder and base64 id decoder with a two-word result buffer.
//
//   channel   dir  word                          handshake
//   chars     in   text_char[8], end_of_text[1]  valid/ready
//   results   out  link_id[32], parse_status[2]  valid/ready
//
// One character per cycle while chars is not stalled; the scan state updates at the accept edge.
// A result word appears in the cycle after its end_of_text character unless the
// output slot holds a word that is not taken; it then waits in the skid slot.
// rst is synchronous and clears the scan state and both result slots.
// chars stalls while the skid slot holds a word, which moves to the output slot
// at the next edge where the output word is taken.
`timescale 1ns / 1ps
module chat_link_base64_id_extractor (
  input  logic                   clk,
  input  logic                   rst,
  chlb64_char_if.sink            chars,
  chlb64_result_if.source        results
);
  import chlb64_pkg::*;

  scan_phase_t                phase, phase_next;
  logic                       saw_open, saw_open_next;
  logic [ACC_W-1:0]           acc, acc_next;
  logic signed [PEND_W-1:0]   pend, pend_next;
  logic [COUNT_W-1:0]         count, count_next;
  logic [ID_W-1:0]            id, id_next;

  logic                       out_valid, skid_valid;
  result_word_t               out_word, skid_word, res_word;

  b64_code_t                  code;
  logic [ACC_W-1:0]           acc_shift;
  logic signed [PEND_W-1:0]   pend_add;
  logic [CHAR_W-1:0]          dec_byte;
  logic                       accept, res_valid;

  assign chars.ready = !skid_valid;
  assign accept      = chars.valid && chars.ready;
  assign code        = b64_lookup(chars.text_char);

  always_comb begin
    phase_next    = phase;
    saw_open_next = saw_open;
    acc_next      = acc;
    pend_next     = pend;
    count_next    = count;
    id_next       = id;
    acc_shift     = {acc[ACC_W-7:0], code.value};
    pend_add      = pend + 4'sd6;
    dec_byte      = CHAR_W'(acc_shift >> pend_add[2:0]);
    case (phase)
      PH_SEARCH: begin
        if (chars.text_char == CHAR_AMPERSAND && saw_open) begin
          phase_next = PH_DECODE;
        end
        saw_open_next = (chars.text_char == CHAR_OPEN_BRACKET);
      end
      PH_DECODE, PH_PADDED: begin
        if (chars.text_char == CHAR_CLOSE_BRACKET) begin
          phase_next = PH_CLOSED;
        end else if (phase == PH_DECODE) begin
          if (chars.text_char == CHAR_PAD) begin
            phase_next = PH_PADDED;
          end else if (code.hit) begin
            acc_next  = acc_shift;
            pend_next = pend_add;
            if (!pend_add[PEND_W-1]) begin
              pend_next = pend_add - 4'sd8;
              case (count)
                3'd1:    id_next = id | {24'd0, dec_byte};
                3'd2:    id_next = id | {16'd0, dec_byte, 8'd0};
                3'd3:    id_next = id | {8'd0, dec_byte, 16'd0};
                3'd4:    id_next = id | {dec_byte, 24'd0};
                default: id_next = id;
              endcase
              if (count < COUNT_FULL) begin
                count_next = count + 3'd1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid             = accept && chars.end_of_text;
    res_word.link_id      = '0;
    if (phase_next == PH_SEARCH) begin
      res_word.parse_status = ST_NO_LINK;
    end else if (phase_next != PH_CLOSED) begin
      res_word.parse_status = ST_UNTERM;
    end else if (count_next < COUNT_FULL) begin
      res_word.parse_status = ST_SHORT;
    end else begin
      res_word.parse_status = ST_OK;
      res_word.link_id      = id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && chars.end_of_text)) begin
      phase    <= PH_SEARCH;
      saw_open <= 1'b0;
      acc      <= '0;
      pend     <= PEND_RESET;
      count    <= '0;
      id       <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      saw_open <= saw_open_next;
      acc      <= acc_next;
      pend     <= pend_next;
      count    <= count_next;
      id       <= id_next;
    end
  end

  // Output slot plus skid slot; advance skid into output when output drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || results.ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= res_valid;
          if (res_valid) begin
            out_word <= res_word;
          end
        end
      end else if (res_valid) begin
        skid_valid <= 1'b1;
        skid_word  <= res_word;
      end
    end
  end

  assign results.valid        = out_valid;
  assign results.link_id      = out_word.link_id;
  assign results.parse_status = out_word.parse_status;

endmodule

FILE: verif/chlb64_id_check.sv
// Link id checker: predicts each result word from the accepted text words and compares.
`timescale 1ns / 1ps
module chlb64_id_check (
  input  logic     clk,
  input  logic     rst,
  chlb64_char_if   chars,
  chlb64_result_if results,
  output int       mismatches,
  output int       words_owed
);
  import chlb64_pkg::*;

  scan_phase_t                phase;
  logic                       saw_bracket;
  logic [ACC_W-1:0]           acc;
  logic signed [PEND_W-1:0]   pend;
  logic [COUNT_W-1:0]         nbytes;
  logic [ID_W-1:0]            id_acc;
  result_word_t               owed_words[$];
  result_word_t               want;

  function automatic int sextet_of(input logic [CHAR_W-1:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  task automatic clear_scan();
    phase       = PH_SEARCH;
    saw_bracket = 1'b0;
    acc         = '0;
    pend        = PEND_RESET;
    nbytes      = '0;
    id_acc      = '0;
  endtask

  task automatic predict_char(input logic [CHAR_W-1:0] c, input logic last);
    int           v;
    int           shift;
    logic [7:0]   octet;
    result_word_t w;
    case (phase)
      PH_SEARCH: begin
        if (c == CHAR_AMPERSAND && saw_bracket) phase = PH_DECODE;
        saw_bracket = (c == CHAR_OPEN_BRACKET);
      end
      PH_DECODE, PH_PADDED: begin
        if (c == CHAR_CLOSE_BRACKET) begin
          phase = PH_CLOSED;
        end else if (phase == PH_DECODE) begin
          if (c == CHAR_PAD) begin
            phase = PH_PADDED;
          end else begin
            v = sextet_of(c);
            if (v >= 0) begin
              acc  = {acc[ACC_W-7:0], 6'(v)};
              pend = pend + 4'sd6;
              if (pend >= 0) begin
                octet = 8'(acc >> pend[2:0]);
                if (nbytes >= 1 && nbytes <= 4) begin
                  shift = 8 * (int'(nbytes) - 1);
                  id_acc[shift +: 8] = octet;
                end
                if (nbytes < COUNT_FULL) nbytes = nbytes + 1'b1;
                pend = pend - 4'sd8;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      w.link_id = '0;
      if (phase == PH_SEARCH) begin
        w.parse_status = ST_NO_LINK;
      end else if (phase != PH_CLOSED) begin
        w.parse_status = ST_UNTERM;
      end else if (nbytes < COUNT_FULL) begin
        w.parse_status = ST_SHORT;
      end else begin
        w.parse_status = ST_OK;
        w.link_id      = id_acc;
      end
      owed_words.insert(owed_words.size(), w);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      owed_words.delete();
      mismatches = 0;
      words_owed <= 0;
    end else begin
      if (results.valid && results.ready) begin
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual link_id %h status %0d",
                   $time, results.link_id, results.parse_status);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          if (results.link_id !== want.link_id) begin
            $display("%0t: link_id mismatch, expected %h, actual %h",
                     $time, want.link_id, results.link_id);
            mismatches++;
          end
          if (results.parse_status !== want.parse_status) begin
            $display("%0t: parse_status mismatch, expected %0d, actual %0d",
                     $time, want.parse_status, results.parse_status);
            mismatches++;
          end
        end
      end
      if (chars.valid && chars.ready) predict_char(chars.text_char, chars.end_of_text);
      words_owed <= owed_words.size();
    end
  end

endmodule

FILE: verif/chat_link_base64_id_extractor_tb.sv
// Testbench top: drives text words into the link id extractor and gives the verdict.
`timescale 1ns / 1ps
module chat_link_base64_id_extractor_tb;
  import chlb64_pkg::*;

  localparam int    TEXT_WORDS  = 1400;
  localparam int    CYCLE_LIMIT = 300000;
  localparam int    IDLE_PCT    = 38;
  localparam string DIGITS      =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam string FILLERS     = " !#-._~*\n";

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = IDLE_PCT;
  int   cycles = 0;
  int   sent = 0;
  int   mismatches;
  int   words_owed;

  chlb64_char_if   chars_if ();
  chlb64_result_if results_if ();

  chat_link_base64_id_extractor u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  chlb64_id_check u_id_check (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .results    (results_if),
    .mismatches (mismatches),
    .words_owed (words_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("chat_link_base64_id_extractor_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_word(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.text_char   <= c;
    chars_if.end_of_text <= last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    chars_if.valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
  endtask

  function automatic logic [7:0] digit();
    return DIGITS[$urandom_range(63)];
  endfunction

  function automatic logic [7:0] filler();
    return FILLERS[$urandom_range(FILLERS.len() - 1)];
  endfunction

  task automatic add_char(ref logic [7:0] t[$], input logic [7:0] c);
    t.insert(t.size(), c);
  endtask

  task automatic build_text(ref logic [7:0] t[$]);
    int kind;
    int n;
    t.delete();
    kind = $urandom_range(99);
    repeat ($urandom_range(4)) add_char(t, 8'($urandom_range(255)));
    if (kind >= 80 && kind < 90) begin
      add_char(t, 8'($urandom_range(255)));
      return;
    end
    if (kind >= 90) begin
      add_char(t, CHAR_OPEN_BRACKET);
      add_char(t, kind[0] ? 8'h78 : CHAR_OPEN_BRACKET);
    end else begin
      add_char(t, CHAR_OPEN_BRACKET);
    end
    add_char(t, CHAR_AMPERSAND);
    if (kind >= 72 && kind < 80) return;
    n = ($urandom_range(9) == 0) ? $urandom_range(6) : $urandom_range(11, 7);
    repeat (n) begin
      if ($urandom_range(9) == 0) add_char(t, filler());
      add_char(t, digit());
    end
    if ($urandom_range(4) == 0) begin
      add_char(t, CHAR_PAD);
      repeat ($urandom_range(2)) add_char(t, digit());
    end
    if (kind >= 60 && kind < 72) return;
    add_char(t, CHAR_CLOSE_BRACKET);
    repeat ($urandom_range(3)) add_char(t, 8'($urandom_range(255)));
    if ($urandom_range(7) == 0) begin
      add_char(t, CHAR_OPEN_BRACKET);
      add_char(t, CHAR_AMPERSAND);
    end
  endtask

  initial begin
    logic [7:0] text[$];
    bit         paused;
    paused               = 1'b0;
    chars_if.valid       = 1'b0;
    chars_if.text_char   = '0;
    chars_if.end_of_text = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_string("[&]");
    send_string("[&");
    send_string("[&/+z9!Qw0a=]x[&");
    drain();

    while (sent < TEXT_WORDS) begin
      idle_pct = (sent >= 500 && sent < 750) ? 0 : IDLE_PCT;
      build_text(text);
      foreach (text[i]) send_word(text[i], i == text.size() - 1);
      if (!paused && sent >= 900) begin
        paused = 1'b1;
        drain();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("chat_link_base64_id_extractor_tb passed");
    end else begin
      $display("chat_link_base64_id_extractor_tb failed");
    end
    $finish;
  end

endmodule
